/* rtl/bounded_stack_range_search_macros.svh */
// Assertion macros for the bounded stack with range search.
`ifndef BOUNDED_STACK_RANGE_SEARCH_MACROS_SVH
`define BOUNDED_STACK_RANGE_SEARCH_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BSRS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bsrs: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define BSRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bsrs: next-cycle check failed");

`endif

/* rtl/bsrs_pkg.sv */
// Types and codes shared by the stack controller, datapath and top level.
`default_nettype none

package bsrs_pkg;

	localparam logic [2:0] KIND_PUSH   = 3'd0;
	localparam logic [2:0] KIND_POP    = 3'd1;
	localparam logic [2:0] KIND_CLEAR  = 3'd2;
	localparam logic [2:0] KIND_PEEK   = 3'd3;
	localparam logic [2:0] KIND_SEARCH = 3'd4;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FULL    = 2'd1;
	localparam logic [1:0] STATUS_EMPTY   = 2'd2;
	localparam logic [1:0] STATUS_NOMATCH = 2'd3;

	typedef enum logic [1:0] {
		RD_TOP  = 2'd0,
		RD_PTR  = 2'd1,
		RD_NEXT = 2'd2
	} rd_sel_t;

	typedef enum logic [1:0] {
		SRC_NONE = 2'd0,
		SRC_READ = 2'd1,
		SRC_HOLD = 2'd2
	} out_src_t;

	typedef struct packed {
		logic       latch_op;
		logic       ptr_load;
		logic       ptr_dec;
		rd_sel_t    rd_sel;
		logic       push;
		logic       pop;
		logic       clear;
		logic       hold_load;
		logic       hold_clr;
		logic       out_load;
		out_src_t   out_src;
		logic [1:0] out_status;
		logic       out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       empty;
		logic       full;
		logic       match;
		logic       ptr_zero;
		logic       hold_valid;
		logic       out_free;
	} dp_status_t;

endpackage

`default_nettype wire

/* rtl/bounded_stack_range_search.sv */
// Top level of the bounded record stack with range search.
// Push, pop, clear, peek: the request is latched, then S_EXEC registers the result,
// and the next input is taken back in S_IDLE; S_EXEC waits while the result port stalls.
// Search over n records: one record per cycle, top of stack first, through the single
// read port of the record store, pausing while a match waits on a stalled result port.
// Reset clears the fill count and control; record storage is undefined until pushed.
`default_nettype none

`include "bounded_stack_range_search_macros.svh"

module bounded_stack_range_search
	import bsrs_pkg::*;
#(
	parameter int STACK_DEPTH = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         kind,
	input  wire logic [63:0]        rec_name,
	input  wire logic [7:0]         rec_type,
	input  wire logic signed [31:0] rec_value,
	input  wire logic signed [31:0] bound_low,
	input  wire logic signed [31:0] bound_high,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic                    has_record,
	output logic [63:0]             out_name,
	output logic [7:0]              out_type,
	output logic signed [31:0]      out_value,
	output logic                    last
);

	dp_cmd_t    cmd;
	dp_status_t sts;

	bsrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bsrs_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.kind       (kind),
		.rec_name   (rec_name),
		.rec_type   (rec_type),
		.rec_value  (rec_value),
		.bound_low  (bound_low),
		.bound_high (bound_high),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.has_record (has_record),
		.out_name   (out_name),
		.out_type   (out_type),
		.out_value  (out_value),
		.last       (last)
	);

	`BSRS_ASSERT_NEXT(a_busy_after_transfer, clk, arst_n, in_valid && in_ready, !in_ready)
	`BSRS_ASSERT_IMPL(a_no_result_overwrite, clk, arst_n, cmd.out_load, sts.out_free)
	`BSRS_ASSERT_IMPL(a_no_push_when_full, clk, arst_n, cmd.push, !sts.full)
	`BSRS_ASSERT_IMPL(a_no_lost_match, clk, arst_n, cmd.hold_load && sts.hold_valid, cmd.out_load)

endmodule

`default_nettype wire

/* rtl/bsrs_ctrl.sv */
// Controller state machine sequencing stack operations and the range walk.
`default_nettype none

module bsrs_ctrl
	import bsrs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire dp_status_t sts,
	output dp_cmd_t         cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_EXEC   = 4'b0010,
		S_SCAN   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   stall;

	assign in_ready = (state_q == S_IDLE);
	assign stall    = sts.match && sts.hold_valid && !sts.out_free;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.rd_sel     = RD_PTR;
		cmd.out_src    = SRC_NONE;
		cmd.out_status = STATUS_OK;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_op = 1'b1;
					cmd.ptr_load = 1'b1;
					cmd.rd_sel   = RD_TOP;
					state_d      = S_EXEC;
				end
			end
			S_EXEC: begin
				case (sts.kind)
					KIND_PUSH: begin
						if (sts.out_free) begin
							cmd.out_load   = 1'b1;
							cmd.out_last   = 1'b1;
							cmd.out_status = sts.full ? STATUS_FULL : STATUS_OK;
							cmd.push       = !sts.full;
							state_d        = S_IDLE;
						end
					end
					KIND_POP, KIND_PEEK: begin
						if (sts.out_free) begin
							cmd.out_load = 1'b1;
							cmd.out_last = 1'b1;
							if (sts.empty) begin
								cmd.out_status = STATUS_EMPTY;
							end else begin
								cmd.out_src = SRC_READ;
								cmd.pop     = (sts.kind == KIND_POP);
							end
							state_d = S_IDLE;
						end
					end
					KIND_CLEAR: begin
						if (sts.out_free) begin
							cmd.out_load = 1'b1;
							cmd.out_last = 1'b1;
							cmd.clear    = 1'b1;
							state_d      = S_IDLE;
						end
					end
					KIND_SEARCH: begin
						if (!sts.empty) begin
							state_d = S_SCAN;
						end else if (sts.out_free) begin
							cmd.out_load   = 1'b1;
							cmd.out_last   = 1'b1;
							cmd.out_status = STATUS_EMPTY;
							state_d        = S_IDLE;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				if (!stall) begin
					cmd.rd_sel  = RD_NEXT;
					cmd.ptr_dec = 1'b1;
					if (sts.match) begin
						cmd.hold_load = 1'b1;
						if (sts.hold_valid) begin
							cmd.out_load = 1'b1;
							cmd.out_src  = SRC_HOLD;
						end
					end
					if (sts.ptr_zero) begin
						state_d = S_FINISH;
					end
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					cmd.hold_clr = 1'b1;
					if (sts.hold_valid) begin
						cmd.out_src = SRC_HOLD;
					end else begin
						cmd.out_status = STATUS_NOMATCH;
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/bsrs_datapath.sv */
// Datapath: record storage, fill count, walk pointer, match hold and result register.
`default_nettype none

module bsrs_datapath
	import bsrs_pkg::*;
#(
	parameter int STACK_DEPTH = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dp_cmd_t            cmd,
	output dp_status_t              sts,
	input  wire logic [2:0]         kind,
	input  wire logic [63:0]        rec_name,
	input  wire logic [7:0]         rec_type,
	input  wire logic signed [31:0] rec_value,
	input  wire logic signed [31:0] bound_low,
	input  wire logic signed [31:0] bound_high,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic                    has_record,
	output logic [63:0]             out_name,
	output logic [7:0]              out_type,
	output logic signed [31:0]      out_value,
	output logic                    last
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [63:0]        name_mem  [STACK_DEPTH];
	logic [7:0]         type_mem  [STACK_DEPTH];
	logic signed [31:0] value_mem [STACK_DEPTH];

	logic [2:0]         kind_q;
	logic [63:0]        op_name_q;
	logic [7:0]         op_type_q;
	logic signed [31:0] op_value_q;
	logic signed [31:0] op_low_q;
	logic signed [31:0] op_high_q;

	logic [CW-1:0]      fill_q;
	logic [AW-1:0]      ptr_q;
	logic [AW-1:0]      top_idx;
	logic [AW-1:0]      rd_addr_c;

	logic [63:0]        rd_name_q;
	logic [7:0]         rd_type_q;
	logic signed [31:0] rd_value_q;

	logic               hold_valid_q;
	logic [63:0]        hold_name_q;
	logic [7:0]         hold_type_q;
	logic signed [31:0] hold_value_q;

	logic               out_valid_q;
	logic [1:0]         status_q;
	logic               has_record_q;
	logic [63:0]        out_name_q;
	logic [7:0]         out_type_q;
	logic signed [31:0] out_value_q;
	logic               last_q;

	assign top_idx = AW'(fill_q - CW'(1));

	always_comb begin
		case (cmd.rd_sel)
			RD_TOP:  rd_addr_c = top_idx;
			RD_NEXT: rd_addr_c = ptr_q - AW'(1);
			default: rd_addr_c = ptr_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			name_mem[AW'(fill_q)]  <= op_name_q;
			type_mem[AW'(fill_q)]  <= op_type_q;
			value_mem[AW'(fill_q)] <= op_value_q;
		end
		rd_name_q  <= name_mem[rd_addr_c];
		rd_type_q  <= type_mem[rd_addr_c];
		rd_value_q <= value_mem[rd_addr_c];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_op) begin
			kind_q     <= kind;
			op_name_q  <= rec_name;
			op_type_q  <= rec_type;
			op_value_q <= rec_value;
			op_low_q   <= bound_low;
			op_high_q  <= bound_high;
		end
		if (cmd.ptr_load) begin
			ptr_q <= top_idx;
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - AW'(1);
		end
		if (cmd.hold_load) begin
			hold_name_q  <= rd_name_q;
			hold_type_q  <= rd_type_q;
			hold_value_q <= rd_value_q;
		end
		if (cmd.out_load) begin
			status_q <= cmd.out_status;
			last_q   <= cmd.out_last;
			case (cmd.out_src)
				SRC_READ: begin
					has_record_q <= 1'b1;
					out_name_q   <= rd_name_q;
					out_type_q   <= rd_type_q;
					out_value_q  <= rd_value_q;
				end
				SRC_HOLD: begin
					has_record_q <= 1'b1;
					out_name_q   <= hold_name_q;
					out_type_q   <= hold_type_q;
					out_value_q  <= hold_value_q;
				end
				default: begin
					has_record_q <= 1'b0;
					out_name_q   <= '0;
					out_type_q   <= '0;
					out_value_q  <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				fill_q <= '0;
			end else if (cmd.push) begin
				fill_q <= fill_q + CW'(1);
			end else if (cmd.pop) begin
				fill_q <= fill_q - CW'(1);
			end
			if (cmd.hold_clr) begin
				hold_valid_q <= 1'b0;
			end else if (cmd.hold_load) begin
				hold_valid_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.kind       = kind_q;
	assign sts.empty      = (fill_q == '0);
	assign sts.full       = (fill_q == CW'(STACK_DEPTH));
	assign sts.match      = (rd_value_q > op_low_q) && (rd_value_q < op_high_q);
	assign sts.ptr_zero   = (ptr_q == '0);
	assign sts.hold_valid = hold_valid_q;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign has_record = has_record_q;
	assign out_name   = out_name_q;
	assign out_type   = out_type_q;
	assign out_value  = out_value_q;
	assign last       = last_q;

endmodule

`default_nettype wire

/* tb/sv/tb_bsrs_scoreboard_pkg.sv */
// Scoreboard for the bounded record stack: shadow copy of the stack and the results still awaited.
package tb_bsrs_scoreboard_pkg;
	import bsrs_pkg::*;

	localparam int DEPTH = 8;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] name;
		logic [7:0]  rtype;
		logic [31:0] value;
		logic [31:0] lo;
		logic [31:0] hi;
	} stack_op_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        has_record;
		logic [63:0] name;
		logic [7:0]  rtype;
		logic [31:0] value;
		logic        last;
	} stack_result_t;

	class stack_scoreboard;
		logic [63:0]   shadow_name [DEPTH];
		logic [7:0]    shadow_type [DEPTH];
		logic [31:0]   shadow_value [DEPTH];
		int            fill;
		int            errors;
		stack_result_t awaited_results[$];

		function new();
			fill = 0;
			errors = 0;
		endfunction

		function stack_result_t bare_result(logic [1:0] st);
			stack_result_t r;
			r = '0;
			r.status = st;
			r.last = 1'b1;
			return r;
		endfunction

		function stack_result_t record_result(int idx, logic lst);
			stack_result_t r;
			r.status = STATUS_OK;
			r.has_record = 1'b1;
			r.name = shadow_name[idx];
			r.rtype = shadow_type[idx];
			r.value = shadow_value[idx];
			r.last = lst;
			return r;
		endfunction

		function void note_transfer(stack_op_t op);
			int hits;
			hits = 0;
			case (op.kind)
				KIND_PUSH: begin
					if (fill >= DEPTH) begin
						awaited_results.push_back(bare_result(STATUS_FULL));
					end else begin
						shadow_name[fill] = op.name;
						shadow_type[fill] = op.rtype;
						shadow_value[fill] = op.value;
						fill++;
						awaited_results.push_back(bare_result(STATUS_OK));
					end
				end
				KIND_POP: begin
					if (fill == 0) begin
						awaited_results.push_back(bare_result(STATUS_EMPTY));
					end else begin
						fill--;
						awaited_results.push_back(record_result(fill, 1'b1));
					end
				end
				KIND_CLEAR: begin
					fill = 0;
					awaited_results.push_back(bare_result(STATUS_OK));
				end
				KIND_PEEK: begin
					if (fill == 0)
						awaited_results.push_back(bare_result(STATUS_EMPTY));
					else
						awaited_results.push_back(record_result(fill - 1, 1'b1));
				end
				KIND_SEARCH: begin
					if (fill == 0) begin
						awaited_results.push_back(bare_result(STATUS_EMPTY));
					end else begin
						// walk top to bottom, mark the final hit as last
						for (int i = fill - 1; i >= 0; i--) begin
							if ($signed(shadow_value[i]) > $signed(op.lo) &&
							    $signed(shadow_value[i]) < $signed(op.hi)) begin
								awaited_results.push_back(record_result(i, 1'b0));
								hits++;
							end
						end
						if (hits == 0)
							awaited_results.push_back(bare_result(STATUS_NOMATCH));
						else
							awaited_results[awaited_results.size() - 1].last = 1'b1;
					end
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(stack_result_t got);
			stack_result_t want;
			if (awaited_results.size() == 0) begin
				report($sformatf("result with none awaited, status %0d", got.status));
				return;
			end
			want = awaited_results.pop_front();
			if (got.status !== want.status)
				report($sformatf("status got %0d want %0d", got.status, want.status));
			if (got.has_record !== want.has_record)
				report($sformatf("has_record got %0b want %0b", got.has_record, want.has_record));
			if (got.name !== want.name)
				report($sformatf("out_name got %h want %h", got.name, want.name));
			if (got.rtype !== want.rtype)
				report($sformatf("out_type got %h want %h", got.rtype, want.rtype));
			if (got.value !== want.value)
				report($sformatf("out_value got %h want %h", got.value, want.value));
			if (got.last !== want.last)
				report($sformatf("last got %0b want %0b", got.last, want.last));
		endtask
	endclass

endpackage

/* tb/sv/tb_bounded_stack_range_search.sv */
// Testbench top for the bounded record stack with range search.
module tb_bounded_stack_range_search;
	timeunit 1ns;
	timeprecision 1ps;

	import bsrs_pkg::*;
	import tb_bsrs_scoreboard_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [2:0] KIND_UNUSED_A = 3'd5;
	localparam logic [2:0] KIND_UNUSED_C = 3'd7;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         kind;
	logic [63:0]        rec_name;
	logic [7:0]         rec_type;
	logic signed [31:0] rec_value;
	logic signed [31:0] bound_low;
	logic signed [31:0] bound_high;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic               has_record;
	logic [63:0]        out_name;
	logic [7:0]         out_type;
	logic signed [31:0] out_value;
	logic               last;

	stack_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycles = 0;

	bounded_stack_range_search #(.STACK_DEPTH(DEPTH)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.rec_name   (rec_name),
		.rec_type   (rec_type),
		.rec_value  (rec_value),
		.bound_low  (bound_low),
		.bound_high (bound_high),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.has_record (has_record),
		.out_name   (out_name),
		.out_type   (out_type),
		.out_value  (out_value),
		.last       (last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result('{status, has_record, out_name, out_type, out_value, last});
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	function automatic stack_op_t op_of(logic [2:0] k, logic [63:0] nm, logic [7:0] ty,
	                                    logic [31:0] val, logic [31:0] lo, logic [31:0] hi);
		return '{k, nm, ty, val, lo, hi};
	endfunction

	function automatic logic [31:0] near_zero();
		return 32'(int'($urandom_range(0, 60)) - 30);
	endfunction

	function automatic stack_op_t random_op();
		stack_op_t op;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			op.kind = KIND_PUSH;
		else if (pick < 55)
			op.kind = KIND_POP;
		else if (pick < 60)
			op.kind = KIND_CLEAR;
		else if (pick < 70)
			op.kind = KIND_PEEK;
		else if (pick < 94)
			op.kind = KIND_SEARCH;
		else
			op.kind = 3'($urandom_range(KIND_UNUSED_A, KIND_UNUSED_C));
		op.name = {$urandom, $urandom};
		op.rtype = 8'($urandom);
		op.value = ($urandom_range(0, 99) < 80) ? near_zero() : $urandom;
		if ($urandom_range(0, 99) < 85) begin
			op.lo = near_zero() - 32'd5;
			op.hi = op.lo + 32'($urandom_range(0, 40));
		end else begin
			op.lo = $urandom;
			op.hi = $urandom;
		end
		return op;
	endfunction

	task automatic send_op(stack_op_t op);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= op.kind;
		rec_name <= op.name;
		rec_type <= op.rtype;
		rec_value <= op.value;
		bound_low <= op.lo;
		bound_high <= op.hi;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		sb.note_transfer(op);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(int n_items);
		stack_op_t op;
		int sent;
		sent = 0;
		while (sent < n_items) begin
			op = random_op();
			send_op(op);
			if (op.kind <= KIND_SEARCH)
				sent++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		kind = KIND_PUSH;
		rec_name = '0;
		rec_type = '0;
		rec_value = '0;
		bound_low = '0;
		bound_high = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(op_of(KIND_POP, '0, '0, '0, '0, '0));
		send_op(op_of(KIND_PEEK, '0, '0, '0, '0, '0));
		send_op(op_of(KIND_SEARCH, '0, '0, '0, 32'h8000_0000, 32'h7fff_ffff));
		send_op(op_of(KIND_PUSH, '1, 8'hff, 32'h7fff_ffff, '0, '0));
		send_op(op_of(KIND_PUSH, '0, 8'h00, 32'h8000_0000, '0, '0));
		send_op(op_of(KIND_PUSH, 64'h0123_4567_89ab_cdef, 8'h41, 32'd0, '0, '0));
		send_op(op_of(KIND_PUSH, 64'hfedc_ba98_7654_3210, 8'h42, 32'hffff_ffff, '0, '0));
		send_op(op_of(KIND_PUSH, 64'h5555_aaaa_5555_aaaa, 8'h55, 32'd5, '0, '0));
		send_op(op_of(KIND_PUSH, 64'haaaa_5555_aaaa_5555, 8'haa, 32'd10, '0, '0));
		send_op(op_of(KIND_PUSH, 64'h8000_0000_0000_0001, 8'h80, 32'hffff_fff6, '0, '0));
		send_op(op_of(KIND_PUSH, 64'h0000_0001_8000_0000, 8'h01, 32'd6, '0, '0));
		send_op(op_of(KIND_PUSH, 64'hdead_beef_dead_beef, 8'h7f, 32'd1, '0, '0));
		send_op(op_of(KIND_PEEK, '0, '0, '0, '0, '0));
		send_op(op_of(KIND_SEARCH, '0, '0, '0, 32'h8000_0000, 32'h7fff_ffff));
		send_op(op_of(KIND_SEARCH, '0, '0, '0, 32'd0, 32'd0));
		send_op(op_of(KIND_SEARCH, '0, '0, '0, 32'd20, 32'hffff_ffec));
		send_op(op_of(KIND_SEARCH, '0, '0, '0, 32'd5, 32'd6));
		send_op(op_of(KIND_SEARCH, '0, '0, '0, 32'hffff_fff5, 32'd11));
		send_op(op_of(KIND_POP, '0, '0, '0, '0, '0));
		send_op(op_of(KIND_UNUSED_A, '1, 8'hff, 32'd3, '0, '0));
		send_op(op_of(KIND_UNUSED_C, '1, 8'hff, 32'd3, '0, '0));
		send_op(op_of(KIND_CLEAR, '0, '0, '0, '0, '0));
		send_op(op_of(KIND_POP, '0, '0, '0, '0, '0));
		send_op(op_of(KIND_PUSH, 64'h0f0f_0f0f_f0f0_f0f0, 8'h33, 32'd3, '0, '0));
		send_op(op_of(KIND_SEARCH, '0, '0, '0, 32'd2, 32'd4));
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			run_random(35);
			wait_drained();
		end

		recv_stall_pct = 0;
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.awaited_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/bsrs_pkg.sv
rtl/bsrs_ctrl.sv
rtl/bsrs_datapath.sv
rtl/bounded_stack_range_search.sv
tb/sv/tb_bsrs_scoreboard_pkg.sv
tb/sv/tb_bounded_stack_range_search.sv
